// ===== rtl/cvsd_pkg.sv =====
// Package for the class value square dilation block.
// Holds the field widths, register indexes, codes and the structs shared by
// the modules; no dependencies.
package cvsd_pkg;

    // Field widths of the channels and the registers.
    localparam int CLASS_W = 8;
    localparam int RADIUS_W = 4;
    localparam int ROWS_W = 15;
    localparam int COLS_W = 14;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 15;

    // Default sizing of the block.
    localparam int DEF_MAX_COLS = 8192;
    localparam int DEF_MAX_ROWS = 16384;
    localparam int DEF_MAX_RADIUS = 8;

    // Register values after reset.
    localparam logic [CLASS_W-1:0] SEARCH_RST = 8'd0;
    localparam logic [CLASS_W-1:0] FILL_RST = 8'd1;
    localparam logic [RADIUS_W-1:0] RADIUS_RST = 4'd1;
    localparam logic [ROWS_W-1:0] ROWS_RST = 15'd1;
    localparam logic [COLS_W-1:0] COLS_RST = 14'd1;

    // Item codes on the input channel.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Register indexes on the configuration channel.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEARCH = 3'd0,
        CFG_FILL   = 3'd1,
        CFG_RADIUS = 3'd2,
        CFG_ROWS   = 3'd3,
        CFG_COLS   = 3'd4
    } t_cfg_idx;

    // Current register contents.
    typedef struct packed {
        logic [CLASS_W-1:0]  search_class;
        logic [CLASS_W-1:0]  fill_class;
        logic [RADIUS_W-1:0] radius;
        logic [ROWS_W-1:0]   frame_rows;
        logic [COLS_W-1:0]   frame_cols;
    } t_live_cfg;

    // One result item.
    typedef struct packed {
        logic [CLASS_W-1:0] dilated_class;
        logic               frame_last;
    } t_result;

    // Result handed from the core to the output queue.
    typedef struct packed {
        logic    valid;
        t_result res;
    } t_push;

    // Output queue fill state seen by the core.
    typedef struct packed {
        logic [1:0] cnt;
        logic       pop;
    } t_q_stat;

endpackage

// ===== rtl/cvsd_if.sv =====
// Channel interfaces of the class value square dilation block.
// Depends on cvsd_pkg for the field widths.
interface cvsd_pix_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [cvsd_pkg::CLASS_W-1:0] pixel_class;
    modport source (output valid, op, pixel_class, input ready);
    modport sink (input valid, op, pixel_class, output ready);
endinterface

interface cvsd_res_if;
    logic                         valid;
    logic                         ready;
    logic [cvsd_pkg::CLASS_W-1:0] dilated_class;
    logic                         frame_last;
    modport source (output valid, dilated_class, frame_last, input ready);
    modport sink (input valid, dilated_class, frame_last, output ready);
endinterface

interface cvsd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cvsd_pkg::CFG_IDX_W-1:0]  index;
    logic [cvsd_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/class_value_square_dilation.sv =====
// Class value square dilation top level: a result passes the decision stage register
// and then the output queue, and one transaction is taken per cycle unless the queue
// is full or an internal flush step runs. Frames of fewer than radius*cols+radius
// pixels hold off input after their last pixel while the window fills.
// Reset is synchronous and clears all control state; the stores keep their
// contents and row 0 of each frame rebuilds the column store.
module class_value_square_dilation #(
    parameter int MAX_COLS = cvsd_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = cvsd_pkg::DEF_MAX_ROWS,
    parameter int MAX_RADIUS = cvsd_pkg::DEF_MAX_RADIUS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cvsd_pix_if.sink   i_pix,
    cvsd_cfg_if.sink   i_cfg,
    cvsd_res_if.source o_res
);

    cvsd_pkg::t_live_cfg live_cfg;
    cvsd_pkg::t_push     push;
    cvsd_pkg::t_q_stat   qstat;

    // Register file.
    cvsd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_live  (live_cfg)
    );

    // Window core.
    cvsd_core #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_cfg   (live_cfg),
        .i_qstat (qstat),
        .o_push  (push)
    );

    // Output queue.
    cvsd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_qstat (qstat),
        .o_res   (o_res)
    );

endmodule

// ===== rtl/cvsd_cfg.sv =====
// Configuration register file of the class value square dilation block.
// Depends on cvsd_pkg and the cvsd_cfg_if interface.
module cvsd_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    cvsd_cfg_if.sink            i_cfg,
    output cvsd_pkg::t_live_cfg o_live
);

    cvsd_pkg::t_live_cfg r_live;

    // Writes are always taken; unknown indexes are dropped.
    assign i_cfg.ready = 1'b1;
    assign o_live = r_live;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live.search_class <= cvsd_pkg::SEARCH_RST;
            r_live.fill_class <= cvsd_pkg::FILL_RST;
            r_live.radius <= cvsd_pkg::RADIUS_RST;
            r_live.frame_rows <= cvsd_pkg::ROWS_RST;
            r_live.frame_cols <= cvsd_pkg::COLS_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                cvsd_pkg::CFG_SEARCH: begin
                    r_live.search_class <= i_cfg.data[cvsd_pkg::CLASS_W-1:0];
                end
                cvsd_pkg::CFG_FILL: begin
                    r_live.fill_class <= i_cfg.data[cvsd_pkg::CLASS_W-1:0];
                end
                cvsd_pkg::CFG_RADIUS: begin
                    r_live.radius <= i_cfg.data[cvsd_pkg::RADIUS_W-1:0];
                end
                cvsd_pkg::CFG_ROWS: begin
                    r_live.frame_rows <= i_cfg.data[cvsd_pkg::ROWS_W-1:0];
                end
                cvsd_pkg::CFG_COLS: begin
                    r_live.frame_cols <= i_cfg.data[cvsd_pkg::COLS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/cvsd_outq.sv =====
// Two-entry output queue that decouples the core from result backpressure.
// Depends on cvsd_pkg and the cvsd_res_if interface.
module cvsd_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cvsd_pkg::t_push   i_push,
    output cvsd_pkg::t_q_stat o_qstat,
    cvsd_res_if.source        o_res
);

    cvsd_pkg::t_result r_data [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic              pop;

    assign o_res.valid = (r_cnt != 2'd0);
    assign o_res.dilated_class = r_data[r_rp].dilated_class;
    assign o_res.frame_last = r_data[r_rp].frame_last;
    assign pop = o_res.valid && o_res.ready;
    assign o_qstat.cnt = r_cnt;
    assign o_qstat.pop = pop;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_data[r_wp] <= i_push.res;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push.valid} - {1'b0, pop};
        end
    end

endmodule

// ===== rtl/cvsd_core.sv =====
// Dilation core: position counters, the column hit store, the center delay
// ring and the window decision stage. Depends on cvsd_pkg and cvsd_pix_if.
module cvsd_core #(
    parameter int MAX_COLS = cvsd_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = cvsd_pkg::DEF_MAX_ROWS,
    parameter int MAX_RADIUS = cvsd_pkg::DEF_MAX_RADIUS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    cvsd_pix_if.sink            i_pix,
    input  cvsd_pkg::t_live_cfg i_cfg,
    input  cvsd_pkg::t_q_stat   i_qstat,
    output cvsd_pkg::t_push     o_push
);

    localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNW = CAW + 1;
    localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RIW = $clog2(MAX_ROWS + 2 * MAX_RADIUS + 1);
    localparam int RADW = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
    localparam int PW = RADW + CNW;
    localparam int LAG_MAX = MAX_RADIUS * MAX_COLS + MAX_RADIUS;
    localparam int GW = (LAG_MAX > 0) ? $clog2(LAG_MAX + 1) : 1;
    localparam int RING_DEPTH = 2 ** GW;
    localparam int RDW = $clog2(MAX_RADIUS + 2);
    localparam int RD = 2 ** RDW;
    localparam int XW = ((CNW > RADW) ? CNW : RADW) + 1;
    localparam int YW = RIW + RADW + 1;
    localparam int CLW = cvsd_pkg::CLASS_W;

    // Last row of a column that held the search class.
    typedef struct packed {
        logic           v;
        logic [RAW-1:0] row;
    } t_lr;

    // Last column of a row whose vertical window held the search class.
    typedef struct packed {
        logic           v;
        logic [CAW-1:0] col;
    } t_rl;

    // Settings latched at frame start.
    logic [CLW-1:0]  r_lat_search;
    logic [CLW-1:0]  r_lat_fill;
    logic [RADW-1:0] r_lat_rad;
    logic [RAW-1:0]  r_lat_rows_m1;
    logic [CAW-1:0]  r_lat_cols_m1;

    // Frame control.
    logic            r_active;
    logic            r_pix_done;
    logic [RIW-1:0]  r_ri;
    logic [CAW-1:0]  r_ci;
    logic [GW-1:0]   r_gap;
    logic [GW-1:0]   r_wptr;
    logic [GW-1:0]   r_rptr;
    logic [RIW-1:0]  r_orow;
    logic [CAW-1:0]  r_ocol;

    // Decision stage.
    logic            r_s2_valid;
    logic            r_s2_real;
    logic            r_s2_emit;
    logic            r_s2_carry;
    logic            r_s2_last;
    logic            r_s2_clast;
    logic [RIW-1:0]  r_s2_ri;
    logic [CAW-1:0]  r_s2_ci;
    logic [CLW-1:0]  r_s2_pix;
    logic [CAW-1:0]  r_s2_ocol;
    logic [RDW-1:0]  r_s2_oidx;

    // Stores and their read ports.
    t_lr             lr_mem [MAX_COLS];
    t_lr             r_lr_rd;
    logic            r_lrfwd;
    t_lr             r_lrfwd_data;
    logic [CLW-1:0]  ring_mem [RING_DEPTH];
    logic [CLW-1:0]  r_center_rd;
    logic            r_cfwd;
    t_rl             r_rtab [RD];
    t_rl             r_rowlast;

    // Live settings after range limiting.
    int              rows_i;
    int              cols_i;
    int              rad_i;
    logic [RAW-1:0]  live_rows_m1;
    logic [CAW-1:0]  live_cols_m1;
    logic [RADW-1:0] live_rad;

    logic [RAW-1:0]  cur_rows_m1;
    logic [CAW-1:0]  cur_cols_m1;
    logic [RADW-1:0] cur_rad;
    logic [CNW-1:0]  cur_cols;
    logic [PW-1:0]   prod;
    logic [GW-1:0]   lag;

    logic            internal_step;
    logic            credit_ok;
    logic [2:0]      occ;
    logic            acc;
    logic            step_real;
    logic            step;
    logic            emit;
    logic            start;
    logic            ci_last;
    logic            o_last;
    logic            carry;

    t_lr             rd_lr;
    t_lr             cur_lr;
    logic            vh;
    t_rl             rowlast_new;
    t_rl             sel;
    logic            hit;
    logic [RIW-1:0]  rc_w;
    logic [CLW-1:0]  center;
    logic [CLW-1:0]  result;

    // Range limiting of the live settings.
    always_comb begin
        rows_i = int'(i_cfg.frame_rows);
        cols_i = int'(i_cfg.frame_cols);
        rad_i = int'(i_cfg.radius);
        if (rows_i == 0) begin
            rows_i = 1;
        end else if (rows_i > MAX_ROWS) begin
            rows_i = MAX_ROWS;
        end
        if (cols_i == 0) begin
            cols_i = 1;
        end else if (cols_i > MAX_COLS) begin
            cols_i = MAX_COLS;
        end
        if (rad_i > MAX_RADIUS) begin
            rad_i = MAX_RADIUS;
        end
        live_rows_m1 = RAW'(rows_i - 1);
        live_cols_m1 = CAW'(cols_i - 1);
        live_rad = RADW'(rad_i);
    end

    // Settings of the frame in progress, or those a new frame would take.
    assign cur_rows_m1 = r_active ? r_lat_rows_m1 : live_rows_m1;
    assign cur_cols_m1 = r_active ? r_lat_cols_m1 : live_cols_m1;
    assign cur_rad = r_active ? r_lat_rad : live_rad;
    assign cur_cols = {1'b0, cur_cols_m1} + CNW'(1);
    assign prod = PW'(cur_rad) * PW'(cur_cols);
    assign lag = GW'(prod) + GW'(cur_rad);

    // Issue control: one position step per cycle; input steps stall without output queue credit.
    assign internal_step = r_pix_done && (r_gap < lag);
    assign occ = {1'b0, i_qstat.cnt} + {2'b00, r_s2_valid & r_s2_emit};
    assign credit_ok = (occ - {2'b00, i_qstat.pop}) < 3'd2;
    assign i_pix.ready = !internal_step && credit_ok;
    assign acc = i_pix.valid && i_pix.ready;
    assign step_real = acc && (i_pix.op == cvsd_pkg::OP_PIXEL) && !r_pix_done;
    assign step = step_real || internal_step || (acc && r_pix_done);
    assign emit = step && (r_gap >= lag);
    assign start = step_real && !r_active;
    assign ci_last = (r_ci == cur_cols_m1);
    assign o_last = (r_orow == RIW'(cur_rows_m1)) && (r_ocol == cur_cols_m1);
    assign carry = (XW'(r_ocol) + XW'(cur_rad)) > XW'(cur_cols_m1);

    // Latch the settings on the first pixel of a frame.
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_lat_search <= i_cfg.search_class;
            r_lat_fill <= i_cfg.fill_class;
            r_lat_rad <= live_rad;
            r_lat_rows_m1 <= live_rows_m1;
            r_lat_cols_m1 <= live_cols_m1;
        end
    end

    // Input and output position counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pix_done <= 1'b0;
            r_ri <= '0;
            r_ci <= '0;
            r_gap <= '0;
            r_wptr <= '0;
            r_rptr <= '0;
            r_orow <= '0;
            r_ocol <= '0;
        end else if (emit && o_last) begin
            r_active <= 1'b0;
            r_pix_done <= 1'b0;
            r_ri <= '0;
            r_ci <= '0;
            r_gap <= '0;
            r_wptr <= '0;
            r_rptr <= '0;
            r_orow <= '0;
            r_ocol <= '0;
        end else if (step) begin
            if (start) begin
                r_active <= 1'b1;
            end
            if (step_real && ci_last && (r_ri == RIW'(cur_rows_m1))) begin
                r_pix_done <= 1'b1;
            end
            if (ci_last) begin
                r_ci <= '0;
                r_ri <= r_ri + RIW'(1);
            end else begin
                r_ci <= r_ci + CAW'(1);
            end
            if (step_real) begin
                r_wptr <= r_wptr + GW'(1);
            end
            if (emit) begin
                r_rptr <= r_rptr + GW'(1);
                if (r_ocol == cur_cols_m1) begin
                    r_ocol <= '0;
                    r_orow <= r_orow + RIW'(1);
                end else begin
                    r_ocol <= r_ocol + CAW'(1);
                end
            end else begin
                r_gap <= r_gap + GW'(1);
            end
        end
    end

    // Stage register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s2_emit <= 1'b0;
        end else begin
            r_s2_valid <= step;
            r_s2_emit <= emit;
        end
    end

    // Stage register payload.
    always_ff @(posedge i_clk) begin
        r_s2_real <= step_real;
        r_s2_carry <= carry;
        r_s2_last <= o_last;
        r_s2_clast <= ci_last;
        r_s2_ri <= r_ri;
        r_s2_ci <= r_ci;
        r_s2_pix <= i_pix.pixel_class;
        r_s2_ocol <= r_ocol;
        r_s2_oidx <= r_orow[RDW-1:0];
    end

    // Column hit store: read at issue, written back by the decision stage.
    always_ff @(posedge i_clk) begin
        if (r_s2_valid && r_s2_real) begin
            lr_mem[r_s2_ci] <= cur_lr;
        end
        r_lr_rd <= lr_mem[r_ci];
        r_lrfwd <= r_s2_valid && r_s2_real && (r_s2_ci == r_ci);
        r_lrfwd_data <= cur_lr;
    end

    // Center delay ring: pixels in, centers out after the window lag.
    always_ff @(posedge i_clk) begin
        if (step_real) begin
            ring_mem[r_wptr] <= i_pix.pixel_class;
        end
        r_center_rd <= ring_mem[r_rptr];
        r_cfwd <= step_real && (r_rptr == r_wptr);
    end

    // Vertical hit of this column and the running row summary.
    always_comb begin
        rd_lr = r_lrfwd ? r_lrfwd_data : r_lr_rd;
        if (r_s2_real && (r_s2_pix == r_lat_search)) begin
            cur_lr.v = 1'b1;
            cur_lr.row = r_s2_ri[RAW-1:0];
        end else if (r_s2_ri == '0) begin
            cur_lr.v = 1'b0;
            cur_lr.row = '0;
        end else begin
            cur_lr = rd_lr;
        end
        vh = cur_lr.v && ((YW'(cur_lr.row) + (YW'(r_lat_rad) << 1)) >= YW'(r_s2_ri));
        if (vh) begin
            rowlast_new.v = 1'b1;
            rowlast_new.col = r_s2_ci;
        end else if (r_s2_ci == '0) begin
            rowlast_new.v = 1'b0;
            rowlast_new.col = '0;
        end else begin
            rowlast_new = r_rowlast;
        end
        rc_w = r_s2_ri - RIW'(r_lat_rad);
    end

    // Row summaries: running value and one entry per finished center row.
    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_rowlast <= rowlast_new;
            if (r_s2_clast) begin
                r_rtab[rc_w[RDW-1:0]] <= rowlast_new;
            end
        end
    end

    // Window decision and result.
    always_comb begin
        sel = r_s2_carry ? r_rtab[r_s2_oidx] : rowlast_new;
        hit = sel.v && ((XW'(sel.col) + XW'(r_lat_rad)) >= XW'(r_s2_ocol));
        center = r_cfwd ? r_s2_pix : r_center_rd;
        if (center == r_lat_fill) begin
            result = r_lat_fill;
        end else if (hit || (center == r_lat_search)) begin
            result = r_lat_search;
        end else begin
            result = center;
        end
        o_push.valid = r_s2_valid && r_s2_emit;
        o_push.res.dilated_class = result;
        o_push.res.frame_last = r_s2_last;
    end

`ifndef SYNTHESIS
    // A result is never pushed into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid |-> !((i_qstat.cnt == 2'd2) && !i_qstat.pop))
        else $error("result pushed into a full output queue");

    // The gap between input and output positions never exceeds the lag.
    a_gap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_gap <= lag))
        else $error("position gap exceeds window lag");

    // Internal flush steps never take an input transaction.
    a_internal_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        internal_step |-> !i_pix.ready)
        else $error("input accepted during an internal step");

    // The frame closes right after its last result is issued.
    a_frame_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && o_last) |=> (!r_active && !r_pix_done && (r_gap == '0)))
        else $error("frame state not cleared after last result");

    // The issued last result is pushed from the decision stage with frame_last set.
    a_last_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && o_last) |=> (o_push.valid && o_push.res.frame_last))
        else $error("last result not pushed one cycle after issue");
`endif

endmodule

// ===== verif/cvsd_checker.sv =====
// Checker for the class value square dilation block: watches the configuration,
// pixel and result channels, predicts each dilated pixel and compares it.
// Depends on cvsd_pkg and the channel interfaces in cvsd_if.sv.
module cvsd_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    cvsd_pix_if  pix,
    cvsd_cfg_if  cfg,
    cvsd_res_if  res,
    output int   o_err_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import cvsd_pkg::*;

    // Register copies as written through the configuration channel.
    logic [CLASS_W-1:0]  reg_search;
    logic [CLASS_W-1:0]  reg_fill;
    logic [RADIUS_W-1:0] reg_radius;
    logic [ROWS_W-1:0]   reg_rows;
    logic [COLS_W-1:0]   reg_cols;

    // Frame setup taken at the first pixel of each frame.
    logic [CLASS_W-1:0] frm_search, frm_fill;
    int unsigned frm_radius, frm_rows, frm_cols;
    int unsigned in_pos, out_pos;

    // Pixels of the current frame, by raster position.
    logic [CLASS_W-1:0] frame_pixels [int unsigned];
    t_result            dilated_fifo [$];
    int                 err_count;

    assign o_err_count = err_count;
    assign o_pending   = dilated_fifo.size();

    function automatic int unsigned frame_size();
        return frm_rows * frm_cols;
    endfunction

    function automatic int unsigned window_lag();
        return frm_radius * frm_cols + frm_radius;
    endfunction

    // Clamp the live registers into the frame setup.
    function automatic void take_frame_setup();
        frm_search = reg_search;
        frm_fill   = reg_fill;
        frm_radius = (reg_radius > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : 32'(reg_radius);
        frm_rows   = (reg_rows == 0) ? 1 :
                     ((reg_rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : 32'(reg_rows));
        frm_cols   = (reg_cols == 0) ? 1 :
                     ((reg_cols > DEF_MAX_COLS) ? DEF_MAX_COLS : 32'(reg_cols));
    endfunction

    // Work out the next output pixel and queue it.
    function automatic void dilate_next();
        int unsigned row, col, r0, r1, c0, c1;
        logic [CLASS_W-1:0] center;
        logic               hit;
        t_result            item;
        row    = out_pos / frm_cols;
        col    = out_pos % frm_cols;
        center = frame_pixels[out_pos];
        hit    = 1'b0;
        if (center == frm_fill) begin
            item.dilated_class = frm_fill;
        end else if (center == frm_search) begin
            item.dilated_class = frm_search;
        end else begin
            r0 = (row >= frm_radius) ? row - frm_radius : 0;
            r1 = (row + frm_radius < frm_rows) ? row + frm_radius : frm_rows - 1;
            c0 = (col >= frm_radius) ? col - frm_radius : 0;
            c1 = (col + frm_radius < frm_cols) ? col + frm_radius : frm_cols - 1;
            for (int unsigned wr = r0; wr <= r1 && !hit; wr++) begin
                for (int unsigned wc = c0; wc <= c1; wc++) begin
                    if (frame_pixels[wr * frm_cols + wc] == frm_search) begin
                        hit = 1'b1;
                    end
                end
            end
            item.dilated_class = hit ? frm_search : center;
        end
        item.frame_last = (out_pos + 1 == frame_size());
        dilated_fifo.push_back(item);
        out_pos++;
        if (out_pos >= frame_size()) begin
            out_pos = 0;
            in_pos  = 0;
            frame_pixels.delete();
        end
    endfunction

    // One accepted pixel or drain transaction.
    function automatic void accept_item(logic op, logic [CLASS_W-1:0] pixel);
        if (op == OP_PIXEL && in_pos == 0 && out_pos == 0) begin
            take_frame_setup();
        end
        if (op == OP_PIXEL && in_pos < frame_size()) begin
            frame_pixels[in_pos] = pixel;
            in_pos++;
            if (in_pos > out_pos + window_lag()) begin
                dilate_next();
            end
        end else if (in_pos >= frame_size() && out_pos < frame_size()) begin
            dilate_next();
        end
    endfunction

    // Watch the channels at each clock edge.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            reg_search = SEARCH_RST;
            reg_fill   = FILL_RST;
            reg_radius = RADIUS_RST;
            reg_rows   = ROWS_RST;
            reg_cols   = COLS_RST;
            take_frame_setup();
            in_pos  = 0;
            out_pos = 0;
            frame_pixels.delete();
            dilated_fifo.delete();
            err_count = 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_SEARCH: reg_search = cfg.data[CLASS_W-1:0];
                    CFG_FILL:   reg_fill   = cfg.data[CLASS_W-1:0];
                    CFG_RADIUS: reg_radius = cfg.data[RADIUS_W-1:0];
                    CFG_ROWS:   reg_rows   = cfg.data[ROWS_W-1:0];
                    CFG_COLS:   reg_cols   = cfg.data[COLS_W-1:0];
                    default: ;
                endcase
            end
            if (pix.valid && pix.ready) begin
                accept_item(pix.op, pix.pixel_class);
            end
            if (res.valid && res.ready) begin
                if (dilated_fifo.size() == 0) begin
                    $error("unexpected result transaction: dilated_class %0d frame_last %0d",
                           res.dilated_class, res.frame_last);
                    err_count++;
                end else begin
                    want = dilated_fifo.pop_front();
                    if (res.dilated_class !== want.dilated_class) begin
                        $error("dilated_class: expected %0d, actual %0d",
                               want.dilated_class, res.dilated_class);
                        err_count++;
                    end
                    if (res.frame_last !== want.frame_last) begin
                        $error("frame_last: expected %0d, actual %0d",
                               want.frame_last, res.frame_last);
                        err_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// Top of the class value square dilation testbench: clock, reset, frame
// stimulus with bursts and stalls, and the verdict.
// Depends on cvsd_pkg, cvsd_if.sv, cvsd_checker and the block itself.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cvsd_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic i_clk;
    logic i_rst_n;
    int   err_count;
    int   pending;
    int   cycle_count;
    int   burst_left;
    int   random_pixels;
    logic sink_steady;

    // Class values of the frame being sent, for biasing the pixels.
    logic [CLASS_W-1:0] cur_search;
    logic [CLASS_W-1:0] cur_fill;

    cvsd_pix_if pix ();
    cvsd_cfg_if cfg ();
    cvsd_res_if res ();

    class_value_square_dilation u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    cvsd_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .pix         (pix),
        .cfg         (cfg),
        .res         (res),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Result side: long stretches always ready, others stalling at random.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) begin
            sink_steady <= ~sink_steady;
        end
        res.ready <= sink_steady ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    // One configuration transaction; valid stays high for the next write.
    task automatic write_reg(t_cfg_idx idx, int unsigned value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!cfg.ready);
    endtask

    // Write all five registers and remember the classes.
    task automatic setup_frame(int unsigned search, int unsigned fill, int unsigned radius,
                               int unsigned rows, int unsigned cols);
        write_reg(CFG_SEARCH, search);
        write_reg(CFG_FILL, fill);
        write_reg(CFG_RADIUS, radius);
        write_reg(CFG_ROWS, rows);
        write_reg(CFG_COLS, cols);
        cfg.valid <= 1'b0;
        cur_search = search[CLASS_W-1:0];
        cur_fill   = fill[CLASS_W-1:0];
    endtask

    // One pixel channel transaction, with bursts and gaps in between.
    task automatic send_item(logic op, logic [CLASS_W-1:0] pixel);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0) begin
                pix.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        pix.valid       <= 1'b1;
        pix.op          <= op;
        pix.pixel_class <= pixel;
        do @(posedge i_clk); while (!pix.ready);
    endtask

    function automatic logic [CLASS_W-1:0] pick_class(int unsigned search_pct);
        if ($urandom_range(0, 99) < search_pct) begin
            return cur_search;
        end
        case ($urandom_range(0, 2))
            0: return cur_fill;
            default: return CLASS_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Send one frame with early drains, then flush it with drains or spare pixels.
    task automatic run_frame(int unsigned radius, int unsigned rows, int unsigned cols,
                             int unsigned search_pct, int unsigned early_pct);
        int unsigned eff_rows, eff_cols, eff_radius, total, lag, flush;
        eff_radius = (radius > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : radius;
        eff_rows   = (rows == 0) ? 1 : ((rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows);
        eff_cols   = (cols == 0) ? 1 : ((cols > DEF_MAX_COLS) ? DEF_MAX_COLS : cols);
        total = eff_rows * eff_cols;
        lag   = eff_radius * eff_cols + eff_radius;
        flush = (lag < total) ? lag : total;
        for (int unsigned i = 0; i < total; i++) begin
            if ($urandom_range(0, 99) < early_pct) begin
                send_item(OP_DRAIN, CLASS_W'($urandom_range(0, 255)));
            end
            send_item(OP_PIXEL, pick_class(search_pct));
        end
        for (int unsigned i = 0; i < flush; i++) begin
            send_item($urandom_range(0, 3) == 0 ? OP_PIXEL : OP_DRAIN,
                      CLASS_W'($urandom_range(0, 255)));
        end
        pix.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (12) @(posedge i_clk);
    endtask

    initial begin
        int unsigned radius, rows, cols;
        cycle_count     = 0;
        burst_left      = 0;
        random_pixels   = 0;
        sink_steady     = 1'b1;
        pix.valid       = 1'b0;
        pix.op          = OP_PIXEL;
        pix.pixel_class = '0;
        cfg.valid       = 1'b0;
        cfg.index       = CFG_SEARCH;
        cfg.data        = '0;
        res.ready       = 1'b0;
        cur_search      = SEARCH_RST;
        cur_fill        = FILL_RST;
        i_rst_n         = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a drain on an idle block, then a frame at reset settings.
        send_item(OP_DRAIN, 8'hFF);
        run_frame(RADIUS_RST, ROWS_RST, COLS_RST, 30, 30);

        // Extreme classes with an oversized radius that gets clamped.
        setup_frame(255, 0, 15, 3, 4);
        run_frame(15, 3, 4, 20, 20);

        // Fill equal to search, zero radius, zero rows and columns.
        setup_frame(7, 7, 0, 0, 0);
        run_frame(0, 0, 0, 50, 0);

        // Wide single-row frame with the largest radius.
        setup_frame(0, 255, 8, 1, 40);
        run_frame(8, 1, 40, 1, 0);

        // Tall single-column frame.
        setup_frame(170, 85, 2, 40, 1);
        run_frame(2, 40, 1, 1, 0);

        // Random small frames.
        while (random_pixels < 350) begin
            radius = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
            rows   = $urandom_range(1, 7);
            cols   = $urandom_range(1, 9);
            setup_frame($urandom_range(0, 255),
                        ($urandom_range(0, 9) == 0) ? 32'(cur_search) : $urandom_range(0, 255),
                        radius, rows, cols);
            run_frame(radius, rows, cols, $urandom_range(0, 15), $urandom_range(0, 10));
            random_pixels += int'(rows * cols);
        end

        if (err_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cvsd_pkg.sv
rtl/cvsd_if.sv
rtl/cvsd_cfg.sv
rtl/cvsd_outq.sv
rtl/cvsd_core.sv
rtl/class_value_square_dilation.sv
verif/cvsd_checker.sv
verif/tb_top.sv
